### rtl/core/tpt_pkg.sv
// Shared types and constants for the TLB and page-table translator.
// Used by tpt_tlb, tpt_page_table and tlb_page_table_translator.
`timescale 1ns / 1ps

package tpt_pkg;

   localparam int ADDR_W          = 16;
   localparam int OFFSET_BITS     = 8;
   localparam int PAGE_NUM_W      = ADDR_W - OFFSET_BITS;
   localparam int PAGE_NUM_COUNT  = 2 ** PAGE_NUM_W;
   localparam int FRAME_W         = 8;
   localparam int COUNT_W         = 16;

   localparam int TLB_ENTRIES_DEF = 16;
   localparam int PAGE_COUNT_DEF  = 256;
   localparam int FRAME_COUNT_DEF = 256;

   // Outcome of the associative TLB search.
   typedef struct packed {
      logic               hit;
      logic [FRAME_W-1:0] frame;
   } tpt_tlb_result_type;

   // Registered page-table read data.
   typedef struct packed {
      logic               mapped;
      logic [FRAME_W-1:0] frame;
   } tpt_pt_result_type;

endpackage

### rtl/core/tpt_tlb.sv
// Fully associative TLB held in registers with FIFO replacement.
// Depends on tpt_pkg for the lookup result type and frame width.
`timescale 1ns / 1ps

module tpt_tlb
   import tpt_pkg::*;
#(
   parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
   parameter int PAGE_W      = PAGE_NUM_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [PAGE_W-1:0]  lookup_page,
   output tpt_tlb_result_type lookup_result,
   input  logic               fill_en,
   input  logic [PAGE_W-1:0]  fill_page,
   input  logic [FRAME_W-1:0] fill_frame
);

   localparam int PTR_W = $clog2(TLB_ENTRIES);

   logic [TLB_ENTRIES-1:0] valid_ff;
   logic [PAGE_W-1:0]      tag_ff   [TLB_ENTRIES];
   logic [FRAME_W-1:0]     frame_ff [TLB_ENTRIES];
   logic [PTR_W-1:0]       fill_ptr_ff;
   logic [PTR_W-1:0]       fill_ptr_in;

   // Walk from the top down so that the lowest matching slot wins.
   always_comb begin
      lookup_result = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && tag_ff[i] == lookup_page) begin
            lookup_result.hit   = 1'b1;
            lookup_result.frame = frame_ff[i];
         end
      end
   end

   assign fill_ptr_in = (fill_ptr_ff == PTR_W'(TLB_ENTRIES - 1)) ? '0 : fill_ptr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         fill_ptr_ff <= '0;
      end else if (fill_en) begin
         valid_ff[fill_ptr_ff] <= 1'b1;
         fill_ptr_ff           <= fill_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fill_en) begin
         tag_ff[fill_ptr_ff]   <= fill_page;
         frame_ff[fill_ptr_ff] <= fill_frame;
      end
   end

endmodule

### rtl/core/tpt_page_table.sv
// Page table: synchronous frame-number memory plus per-page mapped flags.
// Depends on tpt_pkg for the read result type and frame width.
`timescale 1ns / 1ps

module tpt_page_table
   import tpt_pkg::*;
#(
   parameter int PAGE_COUNT = PAGE_COUNT_DEF,
   parameter int PAGE_W     = PAGE_NUM_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [PAGE_W-1:0]  rd_page,
   output tpt_pt_result_type  rd_result,
   input  logic               wr_en,
   input  logic [PAGE_W-1:0]  wr_page,
   input  logic [FRAME_W-1:0] wr_frame
);

   logic [FRAME_W-1:0]    frame_mem [PAGE_COUNT];
   logic [PAGE_COUNT-1:0] mapped_ff;
   logic                  rd_mapped_ff;
   logic [FRAME_W-1:0]    rd_frame_ff;

   // Frame numbers have no reset; an entry is only trusted once its flag is set.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[wr_page] <= wr_frame;
      end
      if (rd_en) begin
         rd_frame_ff <= frame_mem[rd_page];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mapped_ff    <= '0;
         rd_mapped_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            mapped_ff[wr_page] <= 1'b1;
         end
         if (rd_en) begin
            rd_mapped_ff <= mapped_ff[rd_page];
         end
      end
   end

   assign rd_result.mapped = rd_mapped_ff;
   assign rd_result.frame  = rd_frame_ff;

endmodule

### rtl/core/tlb_page_table_translator.sv
// The accepting edge registers the page number and offset and starts the page-table read;
// the lookup state then decides, and rsp_valid rises with the registered result. No new beat
// is accepted while busy, because of the page-table memory: a registered read, then the
// read-modify-write decision and write-back in the lookup cycle. The receiver cannot stall.
// Reset (synchronous, active high) clears the TLB valid bits, the page mapped flags,
// the frame allocator and both counters at once; no clearing pass is needed.
`timescale 1ns / 1ps

module tlb_page_table_translator
   import tpt_pkg::*;
#(
   parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
   parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
   parameter int FRAME_COUNT = FRAME_COUNT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [ADDR_W-1:0]  req_logical_address,
   output logic               rsp_valid,
   output logic [ADDR_W-1:0]  rsp_physical_address,
   output logic               rsp_tlb_hit,
   output logic               rsp_page_fault,
   output logic               rsp_out_of_frames,
   output logic [COUNT_W-1:0] rsp_hit_count,
   output logic [COUNT_W-1:0] rsp_fault_count
);

   localparam int PAGE_W = $clog2(PAGE_COUNT);
   // Wide enough to hold FRAME_COUNT itself, which marks an exhausted pool.
   localparam int NFF_W  = $clog2(FRAME_COUNT + 1);

   typedef logic [PAGE_W-1:0] page_idx_type;
   typedef page_idx_type      page_wrap_type [PAGE_NUM_COUNT];

   // The raw page number wraps modulo PAGE_COUNT. The wrap is folded into a
   // constant table built at elaboration, indexed by the raw page number.
   function automatic page_wrap_type build_page_wrap();
      page_wrap_type tbl;
      for (int i = 0; i < PAGE_NUM_COUNT; i++) begin
         tbl[i] = PAGE_W'(i % PAGE_COUNT);
      end
      return tbl;
   endfunction

   localparam page_wrap_type PAGE_WRAP = build_page_wrap();

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   state_type                state_ff;
   logic                     accept;
   page_idx_type             req_page;
   page_idx_type             page_ff;
   logic [OFFSET_BITS-1:0]   offset_ff;

   logic [NFF_W-1:0]         next_free_ff;
   logic [NFF_W-1:0]         next_free_in;
   logic [COUNT_W-1:0]       hit_cnt_ff;
   logic [COUNT_W-1:0]       hit_cnt_in;
   logic [COUNT_W-1:0]       fault_cnt_ff;
   logic [COUNT_W-1:0]       fault_cnt_in;

   tpt_tlb_result_type       tlb_result;
   tpt_pt_result_type        pt_result;

   logic                     fill_en;
   logic                     pt_wr_en;
   logic [FRAME_W-1:0]       frame;
   logic                     hit;
   logic                     fault;
   logic                     oof;
   logic [ADDR_W-1:0]        phys_addr;

   logic                     rsp_valid_ff;
   logic [ADDR_W-1:0]        rsp_phys_ff;
   logic                     rsp_hit_ff;
   logic                     rsp_fault_ff;
   logic                     rsp_oof_ff;

   // A beat is accepted only when idle. Because the page-table write happens
   // in the lookup cycle, while busy holds off the next read, a read never
   // overlaps a write to the same entry and no forwarding is required.
   assign busy     = (state_ff == ST_LOOKUP);
   assign accept   = start && !busy;
   assign req_page = PAGE_WRAP[req_logical_address[ADDR_W-1:OFFSET_BITS]];

   tpt_tlb #(
      .TLB_ENTRIES (TLB_ENTRIES),
      .PAGE_W      (PAGE_W)
   ) u_tlb (
      .clock         (clock),
      .reset         (reset),
      .lookup_page   (page_ff),
      .lookup_result (tlb_result),
      .fill_en       (fill_en),
      .fill_page     (page_ff),
      .fill_frame    (frame)
   );

   // The page table is read on the accepting edge so that its data lines up
   // with the registered page number during the lookup cycle.
   tpt_page_table #(
      .PAGE_COUNT (PAGE_COUNT),
      .PAGE_W     (PAGE_W)
   ) u_page_table (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_page   (req_page),
      .rd_result (pt_result),
      .wr_en     (pt_wr_en),
      .wr_page   (page_ff),
      .wr_frame  (frame)
   );

   // Lookup-cycle decision. A TLB hit takes priority; otherwise the page
   // table either supplies a frame or the page faults and takes the next free
   // frame. When the frame pool is exhausted the TLB, page table, allocator and counters stay unchanged.
   always_comb begin
      hit          = 1'b0;
      fault        = 1'b0;
      oof          = 1'b0;
      frame        = '0;
      fill_en      = 1'b0;
      pt_wr_en     = 1'b0;
      next_free_in = next_free_ff;
      hit_cnt_in   = hit_cnt_ff;
      fault_cnt_in = fault_cnt_ff;
      if (state_ff == ST_LOOKUP) begin
         if (tlb_result.hit) begin
            hit        = 1'b1;
            frame      = tlb_result.frame;
            hit_cnt_in = (hit_cnt_ff == '1) ? hit_cnt_ff : hit_cnt_ff + 1'b1;
         end else if (pt_result.mapped) begin
            frame   = pt_result.frame;
            fill_en = 1'b1;
         end else begin
            fault = 1'b1;
            if (next_free_ff >= NFF_W'(FRAME_COUNT)) begin
               oof = 1'b1;
            end else begin
               frame        = FRAME_W'(next_free_ff);
               pt_wr_en     = 1'b1;
               fill_en      = 1'b1;
               next_free_in = next_free_ff + 1'b1;
               fault_cnt_in = (fault_cnt_ff == '1) ? fault_cnt_ff : fault_cnt_ff + 1'b1;
            end
         end
      end
      phys_addr = oof ? '0 : {frame, offset_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         next_free_ff <= '0;
         hit_cnt_ff   <= '0;
         fault_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         next_free_ff <= next_free_in;
         hit_cnt_ff   <= hit_cnt_in;
         fault_cnt_ff <= fault_cnt_in;
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b1;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Payload registers carry no reset; they are qualified by the strobe.
   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff   <= req_page;
         offset_ff <= req_logical_address[OFFSET_BITS-1:0];
      end
      if (state_ff == ST_LOOKUP) begin
         rsp_phys_ff  <= phys_addr;
         rsp_hit_ff   <= hit;
         rsp_fault_ff <= fault;
         rsp_oof_ff   <= oof;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_phys_ff;
   assign rsp_tlb_hit          = rsp_hit_ff;
   assign rsp_page_fault       = rsp_fault_ff;
   assign rsp_out_of_frames    = rsp_oof_ff;
   // The counters are updated on the same edge as the result, so they already
   // include this beat.
   assign rsp_hit_count        = hit_cnt_ff;
   assign rsp_fault_count      = fault_cnt_ff;

   // A result beat is only ever produced by the lookup cycle just before it.
   a_rsp_after_lookup : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_LOOKUP))
      else $error("result beat without a preceding lookup cycle");

   // Running out of frames is a fault that maps nothing and returns address zero.
   a_oof_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_frames) |->
         (rsp_page_fault && !rsp_tlb_hit && rsp_physical_address == '0))
      else $error("out-of-frames beat with inconsistent flags or address");

   // A TLB hit takes priority over the page-table data, so it cannot also fault.
   a_hit_no_fault : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_tlb_hit && rsp_page_fault))
      else $error("beat flagged both as TLB hit and page fault");

   // The frame allocator never passes the size of the frame pool.
   a_alloc_bound : assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= NFF_W'(FRAME_COUNT))
      else $error("free-frame pointer beyond the frame pool");

   // The hit counter only moves in a lookup cycle that hits.
   a_hit_cnt_step : assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && hit_cnt_ff != $past(hit_cnt_ff) |->
         $past(state_ff == ST_LOOKUP && tlb_result.hit))
      else $error("hit counter changed without a TLB hit");

endmodule
